### hw/rtl/safc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safc_pkg
// Shared types and constants of the set-associative FIFO cache tag store.
// ----------------------------------------------------------------------------
package safc_pkg;

  localparam int unsigned MAX_SETS  = 64;
  localparam int unsigned MAX_WAYS  = 8;
  localparam int unsigned ADDR_BITS = 48;

  localparam int unsigned AGE_W = 4;
  localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_SET_BITS    = 2'd1,
    CFG_WAYS_IN_USE = 2'd2,
    CFG_PREFETCH_EN = 2'd3
  } cfg_idx_e;

  localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
  localparam logic [2:0] SET_BITS_RST    = 3'd0;
  localparam logic [3:0] WAYS_RST        = 4'd1;
  localparam logic       PREFETCH_RST    = 1'b0;

  // per-way bookkeeping kept in the metadata memory
  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
  } meta_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK1 = 4'b0100,
    ST_LOOK2 = 4'b1000
  } state_e;

endpackage

### hw/rtl/safc_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safc_lookup
// Tag compare, FIFO victim choice and aging over one set row.
// ----------------------------------------------------------------------------
module safc_lookup #(
  parameter int unsigned MaxWays  = safc_pkg::MAX_WAYS,
  parameter int unsigned AddrBits = safc_pkg::ADDR_BITS,
  localparam int unsigned WayCntW = $clog2(MaxWays + 1)
) (
  input  logic [MaxWays-1:0][AddrBits-1:0] tags_i,
  input  safc_pkg::meta_t [MaxWays-1:0]    meta_i,
  input  logic [AddrBits-1:0]              tag_i,
  input  logic [WayCntW-1:0]               ways_i,
  output logic                             hit_o,
  output logic [MaxWays-1:0][AddrBits-1:0] tags_o,
  output safc_pkg::meta_t [MaxWays-1:0]    meta_o
);

  localparam int unsigned WayIdxW = (MaxWays > 1) ? $clog2(MaxWays) : 1;

  logic                         empty_found;
  logic [WayIdxW-1:0]           empty_pick;
  logic [WayIdxW-1:0]           old_pick;
  logic [WayIdxW-1:0]           pick;
  logic [safc_pkg::AGE_W-1:0]   best_age;
  logic [MaxWays-1:0]           in_use;

  always_comb begin
    hit_o       = 1'b0;
    empty_found = 1'b0;
    empty_pick  = '0;
    old_pick    = '0;
    best_age    = '0;
    for (int w = 0; w < MaxWays; w++) begin
      in_use[w] = (WayCntW'(w) < ways_i);
      if (in_use[w] && meta_i[w].valid && (tags_i[w] == tag_i)) begin
        hit_o = 1'b1;
      end
      if (in_use[w] && !meta_i[w].valid && !empty_found) begin
        empty_found = 1'b1;
        empty_pick  = WayIdxW'(w);
      end
      // strict compare keeps the lowest way on ties
      if (in_use[w] && (meta_i[w].age > best_age)) begin
        best_age = meta_i[w].age;
        old_pick = WayIdxW'(w);
      end
    end
    pick = empty_found ? empty_pick : old_pick;
  end

  always_comb begin
    tags_o = tags_i;
    meta_o = meta_i;
    for (int w = 0; w < MaxWays; w++) begin
      if (in_use[w] && meta_i[w].valid && (meta_i[w].age < safc_pkg::AGE_MAX)) begin
        meta_o[w].age = meta_i[w].age + 1'b1;
      end
    end
    tags_o[pick]       = tag_i;
    meta_o[pick].valid = 1'b1;
    meta_o[pick].age   = safc_pkg::AGE_W'(1);
  end

endmodule

### hw/rtl/set_assoc_fifo_cache_prefetch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_fifo_cache_prefetch
// Tag store of a write-through, write-allocate set-associative cache with
// FIFO replacement and optional next-block prefetch on a miss.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+-----------------------------------
//   request   | start_i, busy_o            | req_type_i, address_i
//   result    | done_o (one-cycle strobe)  | hit_o, memory_reads_o, memory_write_o
//   config    | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// a request runs the demand lookup, then the prefetch lookup when it misses
// with prefetch enabled; each lookup is one read of the set row from the tag
// and metadata memories plus a compare/write-back, and busy_o is low again with done_o
// after reset a clearing pass zeroes the metadata memory, one set row a
// cycle, and busy_o stays high until it has cleared every set row
// the result strobe cannot be held off; config beats are always taken
// ----------------------------------------------------------------------------
module set_assoc_fifo_cache_prefetch #(
  parameter int unsigned MaxSets  = safc_pkg::MAX_SETS,
  parameter int unsigned MaxWays  = safc_pkg::MAX_WAYS,
  parameter int unsigned AddrBits = safc_pkg::ADDR_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             req_type_i,
  input  logic [AddrBits-1:0]              address_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [safc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [safc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [1:0]                       memory_reads_o,
  output logic                             memory_write_o
);

  localparam int unsigned IdxW    = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int unsigned SbMax   = $clog2(MaxSets + 1) - 1;
  localparam int unsigned WayCntW = $clog2(MaxWays + 1);

  // configuration
  logic [4:0] offset_bits_q;
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic       prefetch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= safc_pkg::OFFSET_BITS_RST;
      set_bits_q    <= safc_pkg::SET_BITS_RST;
      ways_q        <= safc_pkg::WAYS_RST;
      prefetch_q    <= safc_pkg::PREFETCH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (safc_pkg::cfg_idx_e'(cfg_index_i))
        safc_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[4:0];
        safc_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data_i[2:0];
        safc_pkg::CFG_WAYS_IN_USE: ways_q        <= cfg_data_i[3:0];
        safc_pkg::CFG_PREFETCH_EN: prefetch_q    <= cfg_data_i[0];
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // effective geometry
  logic [3:0]         eff_sb;
  logic [IdxW-1:0]    set_mask;
  logic [5:0]         tag_shift;
  logic [4:0]         ways_clip;
  logic [WayCntW-1:0] eff_ways;

  always_comb begin
    eff_sb    = ({1'b0, set_bits_q} > 4'(SbMax)) ? 4'(SbMax) : {1'b0, set_bits_q};
    set_mask  = ~({IdxW{1'b1}} << eff_sb);
    tag_shift = 6'(offset_bits_q) + 6'(eff_sb);
    if (ways_q == 4'd0) begin
      ways_clip = 5'd1;
    end else if ({1'b0, ways_q} > 5'(MaxWays)) begin
      ways_clip = 5'(MaxWays);
    end else begin
      ways_clip = {1'b0, ways_q};
    end
    eff_ways = WayCntW'(ways_clip);
  end

  function automatic logic [IdxW-1:0] set_of(input logic [AddrBits-1:0] addr);
    logic [AddrBits-1:0] shifted;
    shifted = addr >> offset_bits_q;
    return shifted[IdxW-1:0] & set_mask;
  endfunction

  function automatic logic [AddrBits-1:0] tag_of(input logic [AddrBits-1:0] addr);
    return addr >> tag_shift;
  endfunction

  // control
  safc_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]     clr_idx_q;
  logic [IdxW-1:0]     set1_q, set2_q, set2;
  logic [AddrBits-1:0] tag1_q, tag2_q, nxt_addr_q;
  logic                req_q;
  logic                fwd_q;
  logic                done_q, hit_q, wr_q;
  logic [1:0]          reads_q;

  // memories
  logic [MaxWays-1:0][AddrBits-1:0] tag_mem [MaxSets];
  safc_pkg::meta_t [MaxWays-1:0]    meta_mem [MaxSets];
  logic [MaxWays-1:0][AddrBits-1:0] tag_rd_q, last_tags_q;
  safc_pkg::meta_t [MaxWays-1:0]    meta_rd_q, last_meta_q;

  logic [IdxW-1:0]                  rd_addr, wr_addr;
  logic                             tag_we, meta_we;
  safc_pkg::meta_t [MaxWays-1:0]    meta_wdata;

  // lookup
  logic [MaxWays-1:0][AddrBits-1:0] lk_tags_in, lk_tags_out;
  safc_pkg::meta_t [MaxWays-1:0]    lk_meta_in, lk_meta_out;
  logic [AddrBits-1:0]              lk_tag;
  logic                             lk_hit;

  logic accept;
  logic in_look;

  assign accept  = start_i && (state_q == safc_pkg::ST_IDLE);
  assign in_look = (state_q == safc_pkg::ST_LOOK1) || (state_q == safc_pkg::ST_LOOK2);

  // set_of also depends on the geometry registers
  always_comb begin
    set2 = set_of(nxt_addr_q);
  end

  always_comb begin
    // second lookup sees the row just written when both land in one set
    if (state_q == safc_pkg::ST_LOOK2 && fwd_q) begin
      lk_tags_in = last_tags_q;
      lk_meta_in = last_meta_q;
    end else begin
      lk_tags_in = tag_rd_q;
      lk_meta_in = meta_rd_q;
    end
    lk_tag = (state_q == safc_pkg::ST_LOOK2) ? tag2_q : tag1_q;
  end

  safc_lookup #(
    .MaxWays  (MaxWays),
    .AddrBits (AddrBits)
  ) u_lookup (
    .tags_i (lk_tags_in),
    .meta_i (lk_meta_in),
    .tag_i  (lk_tag),
    .ways_i (eff_ways),
    .hit_o  (lk_hit),
    .tags_o (lk_tags_out),
    .meta_o (lk_meta_out)
  );

  always_comb begin
    rd_addr    = (state_q == safc_pkg::ST_LOOK1) ? set2 : set_of(address_i);
    tag_we     = in_look && !lk_hit;
    meta_we    = tag_we || (state_q == safc_pkg::ST_CLEAR);
    meta_wdata = (state_q == safc_pkg::ST_CLEAR) ? '0 : lk_meta_out;
    unique case (state_q)
      safc_pkg::ST_CLEAR: wr_addr = clr_idx_q;
      safc_pkg::ST_LOOK2: wr_addr = set2_q;
      default:            wr_addr = set1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= lk_tags_out;
    end
    tag_rd_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[wr_addr] <= meta_wdata;
    end
    meta_rd_q <= meta_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      safc_pkg::ST_CLEAR: begin
        if (clr_idx_q == IdxW'(MaxSets - 1)) begin
          state_d = safc_pkg::ST_IDLE;
        end
      end
      safc_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = safc_pkg::ST_LOOK1;
        end
      end
      safc_pkg::ST_LOOK1: begin
        state_d = (lk_hit || !prefetch_q) ? safc_pkg::ST_IDLE : safc_pkg::ST_LOOK2;
      end
      safc_pkg::ST_LOOK2: begin
        state_d = safc_pkg::ST_IDLE;
      end
      default: begin
        state_d = safc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= safc_pkg::ST_CLEAR;
      clr_idx_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == safc_pkg::ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      done_q <= ((state_q == safc_pkg::ST_LOOK1) && (lk_hit || !prefetch_q)) ||
                (state_q == safc_pkg::ST_LOOK2);
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_type_i;
      set1_q     <= set_of(address_i);
      tag1_q     <= tag_of(address_i);
      nxt_addr_q <= address_i + (AddrBits'(1) << offset_bits_q);
    end
    if (state_q == safc_pkg::ST_LOOK1) begin
      set2_q      <= set2;
      tag2_q      <= tag_of(nxt_addr_q);
      fwd_q       <= (set2 == set1_q);
      last_tags_q <= lk_tags_out;
      last_meta_q <= lk_meta_out;
      hit_q       <= lk_hit;
      wr_q        <= req_q;
      reads_q     <= lk_hit ? 2'd0 : 2'd1;
    end
    if (state_q == safc_pkg::ST_LOOK2) begin
      reads_q <= lk_hit ? 2'd1 : 2'd2;
    end
  end

  assign busy_o         = (state_q != safc_pkg::ST_IDLE);
  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign memory_reads_o = reads_q;
  assign memory_write_o = wr_q;

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while a lookup is still running");

  a_hit_no_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (memory_reads_o == 2'd0))
    else $error("demand hit reported memory reads");

  a_miss_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (memory_reads_o == 2'd1 || memory_reads_o == 2'd2))
    else $error("demand miss with bad read count");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == safc_pkg::ST_LOOK1))
    else $error("accepted request did not start a lookup");

  a_look2_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == safc_pkg::ST_LOOK2) |-> ($past(state_q) == safc_pkg::ST_LOOK1 && prefetch_q))
    else $error("prefetch lookup without a preceding demand miss");

endmodule
